@@ hdl/lib_pkg.sv @@
// Package for the light impulse blink sequencer.
// Holds request and entry codes, field widths, parameter defaults and the result type.
// No dependencies.
package lib_pkg;

    localparam int MAX_STEPS_DEF     = 16;
    localparam int DURATION_BITS_DEF = 24;

    localparam int REQ_TYPE_W = 3;
    localparam int DUR_IN_W   = 24;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [REQ_TYPE_W-1:0] REQ_SET       = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_TOGGLE    = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_SET_STATE = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_IMPULSE   = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_PATTERN   = 3'd4;
    localparam logic [REQ_TYPE_W-1:0] REQ_TICK      = 3'd5;

    localparam logic [KIND_W-1:0] KIND_TIMED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OLD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_REAL_STATE = 1'd1;

    typedef struct packed {
        logic drive_valid;
        logic drive_level;
        logic light_state;
        logic changed_event;
        logic accepted;
        logic pattern_full;
    } res_t;

    typedef struct packed {
        logic append;
        logic mark_loop;
    } tbl_ctl_t;

endpackage

@@ hdl/lib_req_if.sv @@
// Request channel interface of the sequencer.
// Depends on lib_pkg for field widths.
interface lib_req_if;
    logic                          valid;
    logic                          ready;
    logic [lib_pkg::REQ_TYPE_W-1:0] req_type;
    logic                          level;
    logic [lib_pkg::DUR_IN_W-1:0]   duration_ms;
    logic [lib_pkg::KIND_W-1:0]     entry_kind;
    logic                          first_entry;
    logic                          last_entry;

    modport source (output valid, req_type, level, duration_ms, entry_kind, first_entry,
                    last_entry, input ready);
    modport sink (input valid, req_type, level, duration_ms, entry_kind, first_entry,
                  last_entry, output ready);
endinterface

@@ hdl/lib_res_if.sv @@
// Result channel interface of the sequencer.
// No dependencies.
interface lib_res_if;
    logic valid;
    logic ready;
    logic drive_valid;
    logic drive_level;
    logic light_state;
    logic changed_event;
    logic accepted;
    logic pattern_full;

    modport source (output valid, drive_valid, drive_level, light_state, changed_event,
                    accepted, pattern_full, input ready);
    modport sink (input valid, drive_valid, drive_level, light_state, changed_event,
                  accepted, pattern_full, output ready);
endinterface

@@ hdl/lib_cfg_if.sv @@
// Configuration write channel interface of the sequencer.
// Depends on lib_pkg for the register index width.
interface lib_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lib_pkg::CFG_IDX_W-1:0] index;
    logic                          data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/lib_step_table.sv @@
// Pattern step table: level, duration and loop-back flag for each step.
// Depends on lib_pkg for the control struct.
module lib_step_table #(
    parameter int MAX_STEPS     = lib_pkg::MAX_STEPS_DEF,
    parameter int DURATION_BITS = lib_pkg::DURATION_BITS_DEF
) (
    input  logic                          clk,
    input  lib_pkg::tbl_ctl_t             ctl,
    input  logic [$clog2(MAX_STEPS)-1:0]  app_addr,
    input  logic                          app_level,
    input  logic [DURATION_BITS-1:0]      app_dur,
    input  logic [$clog2(MAX_STEPS)-1:0]  loop_addr,
    input  logic [$clog2(MAX_STEPS)-1:0]  flag_addr,
    output logic                          flag_data,
    input  logic [$clog2(MAX_STEPS)-1:0]  rd_addr,
    output logic                          rd_level,
    output logic [DURATION_BITS-1:0]      rd_dur
);

    logic                     level_mem [MAX_STEPS];
    logic [DURATION_BITS-1:0] dur_mem   [MAX_STEPS];
    logic                     loop_mem  [MAX_STEPS];

    always_ff @(posedge clk)
    begin
        if (ctl.append)
        begin
            level_mem[app_addr] <= app_level;
            dur_mem[app_addr]   <= app_dur;
        end
        if (ctl.mark_loop)
        begin
            loop_mem[loop_addr] <= 1'b1;
        end
        if (ctl.append && !(ctl.mark_loop && loop_addr == app_addr))
        begin
            loop_mem[app_addr] <= 1'b0;
        end
    end

    assign flag_data = loop_mem[flag_addr];
    assign rd_level  = level_mem[rd_addr];
    assign rd_dur    = dur_mem[rd_addr];

endmodule

@@ hdl/lib_core.sv @@
// Sequencer core: light state, timer and pattern control, one item per cycle
// while fire is high. Depends on lib_pkg and lib_step_table.
module lib_core #(
    parameter int MAX_STEPS     = lib_pkg::MAX_STEPS_DEF,
    parameter int DURATION_BITS = lib_pkg::DURATION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  logic                            enabled,
    input  logic                            use_real_state,
    input  logic [lib_pkg::REQ_TYPE_W-1:0]  req_type,
    input  logic                            level,
    input  logic [lib_pkg::DUR_IN_W-1:0]    duration_ms,
    input  logic [lib_pkg::KIND_W-1:0]      entry_kind,
    input  logic                            first_entry,
    input  logic                            last_entry,
    output lib_pkg::res_t                   res
);

    localparam int IW = $clog2(MAX_STEPS);
    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int DW = DURATION_BITS;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_STEPS);

    logic          light_reg, light_next;
    logic          running_reg, running_next;
    logic          is_pat_reg, is_pat_next;
    logic [DW-1:0] ticks_reg, ticks_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] loop_idx_reg, loop_idx_next;
    logic          seen_reg, seen_next;
    logic          ntl_reg, ntl_next;
    logic [CW-1:0] cur_reg, cur_next;

    lib_pkg::tbl_ctl_t ctl;
    logic [IW-1:0]     app_addr, loop_addr, rd_addr;
    logic              app_level, flag_data, rd_level;
    logic [DW-1:0]     app_dur, rd_dur, dur;
    logic [CW-1:0]     nx, eff_count, new_count;
    logic              eff_seen;
    logic [CW-1:0]     eff_loop;
    logic              eff_ntl;
    logic              start, start_level;
    logic [DW-1:0]     start_dur;
    logic              drv, drv_level;

    lib_step_table #(
        .MAX_STEPS    (MAX_STEPS),
        .DURATION_BITS(DURATION_BITS)
    ) u_table (
        .clk      (clk),
        .ctl      (ctl),
        .app_addr (app_addr),
        .app_level(app_level),
        .app_dur  (app_dur),
        .loop_addr(loop_addr),
        .flag_addr(cur_reg[IW-1:0]),
        .flag_data(flag_data),
        .rd_addr  (rd_addr),
        .rd_level (rd_level),
        .rd_dur   (rd_dur)
    );

    assign dur       = DW'(duration_ms);
    assign nx        = flag_data ? loop_idx_reg : cur_reg + CW'(1);
    assign eff_count = first_entry ? '0 : count_reg;
    assign eff_seen  = first_entry ? 1'b0 : seen_reg;
    assign eff_loop  = first_entry ? '0 : loop_idx_reg;
    assign eff_ntl   = first_entry ? 1'b1 : ntl_reg;
    assign app_addr  = eff_count[IW-1:0];
    assign loop_addr = IW'(new_count - CW'(1));
    assign rd_addr   = (req_type == lib_pkg::REQ_TICK) ? nx[IW-1:0] : '0;

    always_comb
    begin
        light_next    = light_reg;
        running_next  = running_reg;
        is_pat_next   = is_pat_reg;
        ticks_next    = ticks_reg;
        count_next    = count_reg;
        loop_idx_next = loop_idx_reg;
        seen_next     = seen_reg;
        ntl_next      = ntl_reg;
        cur_next      = cur_reg;
        ctl           = '0;
        app_level     = 1'b0;
        app_dur       = '0;
        new_count     = eff_count;
        start         = 1'b0;
        start_level   = rd_level;
        start_dur     = rd_dur;
        drv           = 1'b0;
        drv_level     = 1'b0;
        res           = '0;
        res.accepted  = (req_type <= lib_pkg::REQ_TICK);

        if (req_type == lib_pkg::REQ_TICK)
        begin
            if (running_reg)
            begin
                if (ticks_reg <= DW'(1))
                begin
                    running_next = 1'b0;
                    ticks_next   = '0;
                    if (!is_pat_reg)
                    begin
                        drv = 1'b1;
                    end
                    else if (cur_reg < count_reg)
                    begin
                        cur_next = nx;
                        start    = (nx < count_reg);
                    end
                end
                else
                begin
                    ticks_next = ticks_reg - DW'(1);
                end
            end
        end
        else if (enabled && req_type < lib_pkg::REQ_TICK)
        begin
            case (req_type) inside
                lib_pkg::REQ_SET, lib_pkg::REQ_TOGGLE:
                begin
                    running_next = 1'b0;
                    drv          = 1'b1;
                    drv_level    = (req_type == lib_pkg::REQ_SET) ? level : !light_reg;
                end
                lib_pkg::REQ_SET_STATE:
                begin
                    light_next        = level;
                    res.changed_event = 1'b1;
                end
                lib_pkg::REQ_IMPULSE:
                begin
                    drv          = 1'b1;
                    drv_level    = 1'b1;
                    running_next = 1'b1;
                    is_pat_next  = 1'b0;
                    ticks_next   = dur;
                end
                default:
                begin
                    if (first_entry)
                    begin
                        running_next = 1'b0;
                    end
                    seen_next     = eff_seen;
                    loop_idx_next = eff_loop;
                    ntl_next      = eff_ntl;
                    if (entry_kind inside {lib_pkg::KIND_TIMED, lib_pkg::KIND_OLD})
                    begin
                        if (eff_count >= MAX_C)
                        begin
                            res.pattern_full = 1'b1;
                        end
                        else
                        begin
                            ctl.append = 1'b1;
                            new_count  = eff_count + CW'(1);
                            if (entry_kind == lib_pkg::KIND_TIMED)
                            begin
                                app_level = eff_ntl;
                                app_dur   = dur;
                                ntl_next  = !eff_ntl;
                            end
                            else
                            begin
                                app_level = light_reg;
                            end
                        end
                    end
                    else if (entry_kind == lib_pkg::KIND_LOOP && !eff_seen)
                    begin
                        seen_next     = 1'b1;
                        loop_idx_next = eff_count;
                    end
                    count_next = new_count;
                    if (last_entry)
                    begin
                        running_next  = 1'b0;
                        ctl.mark_loop = seen_next && (new_count > loop_idx_next);
                        cur_next      = '0;
                        start         = (new_count != '0);
                        if (ctl.append && app_addr == '0)
                        begin
                            start_level = app_level;
                            start_dur   = app_dur;
                        end
                    end
                end
            endcase
        end

        if (start)
        begin
            drv          = 1'b1;
            drv_level    = start_level;
            ticks_next   = start_dur;
            running_next = 1'b1;
            is_pat_next  = 1'b1;
        end
        if (drv)
        begin
            res.drive_valid = 1'b1;
            res.drive_level = drv_level;
            if (!use_real_state)
            begin
                light_next        = drv_level;
                res.changed_event = 1'b1;
            end
        end
        res.light_state = light_next;
        if (!fire)
        begin
            ctl = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg    <= 1'b0;
            running_reg  <= 1'b0;
            is_pat_reg   <= 1'b0;
            ticks_reg    <= '0;
            count_reg    <= '0;
            loop_idx_reg <= '0;
            seen_reg     <= 1'b0;
            ntl_reg      <= 1'b1;
            cur_reg      <= '0;
        end
        else if (fire)
        begin
            light_reg    <= light_next;
            running_reg  <= running_next;
            is_pat_reg   <= is_pat_next;
            ticks_reg    <= ticks_next;
            count_reg    <= count_next;
            loop_idx_reg <= loop_idx_next;
            seen_reg     <= seen_next;
            ntl_reg      <= ntl_next;
            cur_reg      <= cur_next;
        end
    end

endmodule

@@ hdl/light_impulse_blink_sequencer.sv @@
// Light impulse blink sequencer top level; depends on lib_pkg, the interfaces and lib_core.
// An accepted item is held in the input register and its result then in the result
// register. Throughput is one item per cycle while results are taken.
// Asynchronous active-low reset clears the control state, sets enabled to one and
// use_real_state to zero. The step table is not cleared; only appended entries are read.
module light_impulse_blink_sequencer #(
    parameter int MAX_STEPS     = lib_pkg::MAX_STEPS_DEF,
    parameter int DURATION_BITS = lib_pkg::DURATION_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    lib_req_if.sink  req,
    lib_res_if.source res,
    lib_cfg_if.sink  cfg
);

    logic                           in_valid_reg;
    logic [lib_pkg::REQ_TYPE_W-1:0] req_type_reg;
    logic                           level_reg;
    logic [lib_pkg::DUR_IN_W-1:0]   dur_reg;
    logic [lib_pkg::KIND_W-1:0]     kind_reg;
    logic                           first_reg;
    logic                           last_reg;
    logic                           res_valid_reg;
    lib_pkg::res_t                  res_reg, res_next;
    logic                           enabled_reg;
    logic                           use_real_reg;
    logic                           advance, fire, take;

    assign advance   = !res_valid_reg || res.ready;
    assign fire      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;
    assign take      = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    lib_core #(
        .MAX_STEPS    (MAX_STEPS),
        .DURATION_BITS(DURATION_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .enabled       (enabled_reg),
        .use_real_state(use_real_reg),
        .req_type      (req_type_reg),
        .level         (level_reg),
        .duration_ms   (dur_reg),
        .entry_kind    (kind_reg),
        .first_entry   (first_reg),
        .last_entry    (last_reg),
        .res           (res_next)
    );

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_type_reg <= req.req_type;
            level_reg    <= req.level;
            dur_reg      <= req.duration_ms;
            kind_reg     <= req.entry_kind;
            first_reg    <= req.first_entry;
            last_reg     <= req.last_entry;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            enabled_reg   <= 1'b1;
            use_real_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    lib_pkg::CFG_ENABLED:        enabled_reg  <= cfg.data;
                    lib_pkg::CFG_USE_REAL_STATE: use_real_reg <= cfg.data;
                    default:                     enabled_reg  <= enabled_reg;
                endcase
            end
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.drive_valid   = res_reg.drive_valid;
    assign res.drive_level   = res_reg.drive_level;
    assign res.light_state   = res_reg.light_state;
    assign res.changed_event = res_reg.changed_event;
    assign res.accepted      = res_reg.accepted;
    assign res.pattern_full  = res_reg.pattern_full;

endmodule

@@ bench/blink_sequencer_checker.sv @@
// Checker for the light impulse blink sequencer: it follows the request, result and
// configuration channels, predicts every result item and compares it field by field.
// Depends on lib_pkg and the three channel interfaces.
module blink_sequencer_checker (
    input  logic clk,
    input  logic rst_n,
    lib_req_if   req,
    lib_res_if   res,
    lib_cfg_if   cfg,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_STEPS = lib_pkg::MAX_STEPS_DEF;
    localparam int DUE_DEPTH = 8;

    logic          en_reg;
    logic          real_reg;
    logic          lamp;
    logic          tmr_on;
    logic          tmr_pattern;
    logic [23:0]   tmr_left;
    logic          alt_level;
    logic          loop_found;
    logic [4:0]    loop_at;
    logic [4:0]    n_steps;
    logic [4:0]    play_idx;
    logic          step_lvl [MAX_STEPS];
    logic [23:0]   step_len [MAX_STEPS];
    logic [4:0]    step_nxt [MAX_STEPS];
    lib_pkg::res_t outcome;
    lib_pkg::res_t due_mem [DUE_DEPTH];
    int            due_wr;
    int            due_rd;

    function automatic void drive_lamp(logic v);
        outcome.drive_valid = 1'b1;
        outcome.drive_level = v;
        if (!real_reg)
        begin
            lamp = v;
            outcome.changed_event = 1'b1;
        end
    endfunction

    function automatic void start_step(logic [4:0] idx);
        drive_lamp(step_lvl[idx[3:0]]);
        tmr_left = step_len[idx[3:0]];
        tmr_on = 1'b1;
        tmr_pattern = 1'b1;
    endfunction

    function automatic logic append_step(logic v, logic [23:0] d);
        if (n_steps >= 5'(MAX_STEPS))
            return 1'b1;
        step_lvl[n_steps[3:0]] = v;
        step_len[n_steps[3:0]] = d;
        step_nxt[n_steps[3:0]] = n_steps + 5'd1;
        n_steps = n_steps + 5'd1;
        return 1'b0;
    endfunction

    function automatic lib_pkg::res_t light_outcome(logic [2:0] rq, logic lv, logic [23:0] dur,
                                                    logic [1:0] kind, logic first, logic last);
        outcome = '0;
        outcome.accepted = 1'b1;
        if (rq > lib_pkg::REQ_TICK)
            outcome.accepted = 1'b0;
        else if (rq == lib_pkg::REQ_TICK)
        begin
            if (tmr_on)
            begin
                if (tmr_left <= 24'd1)
                begin
                    tmr_on = 1'b0;
                    tmr_left = '0;
                    if (!tmr_pattern)
                        drive_lamp(1'b0);
                    else if (play_idx < n_steps)
                    begin
                        play_idx = step_nxt[play_idx[3:0]];
                        if (play_idx < n_steps)
                            start_step(play_idx);
                    end
                end
                else
                    tmr_left = tmr_left - 24'd1;
            end
        end
        else if (en_reg)
        begin
            case (rq) inside
                lib_pkg::REQ_SET, lib_pkg::REQ_TOGGLE:
                begin
                    tmr_on = 1'b0;
                    drive_lamp(rq == lib_pkg::REQ_SET ? lv : ~lamp);
                end
                lib_pkg::REQ_SET_STATE:
                begin
                    lamp = lv;
                    outcome.changed_event = 1'b1;
                end
                lib_pkg::REQ_IMPULSE:
                begin
                    drive_lamp(1'b1);
                    tmr_on = 1'b1;
                    tmr_pattern = 1'b0;
                    tmr_left = dur;
                end
                default:
                begin
                    if (first)
                    begin
                        tmr_on = 1'b0;
                        n_steps = '0;
                        loop_found = 1'b0;
                        loop_at = '0;
                        alt_level = 1'b1;
                    end
                    case (kind)
                        lib_pkg::KIND_TIMED:
                        begin
                            outcome.pattern_full = append_step(alt_level, dur);
                            if (!outcome.pattern_full)
                                alt_level = ~alt_level;
                        end
                        lib_pkg::KIND_OLD:
                            outcome.pattern_full = append_step(lamp, '0);
                        lib_pkg::KIND_LOOP:
                        begin
                            if (!loop_found)
                            begin
                                loop_found = 1'b1;
                                loop_at = n_steps;
                            end
                        end
                        default:
                            ;
                    endcase
                    if (last)
                    begin
                        tmr_on = 1'b0;
                        if (loop_found && n_steps > loop_at)
                            step_nxt[4'(n_steps - 5'd1)] = loop_at;
                        play_idx = '0;
                        if (n_steps > 5'd0)
                            start_step(5'd0);
                    end
                end
            endcase
        end
        outcome.light_state = lamp;
        return outcome;
    endfunction

    function automatic void check_result(lib_pkg::res_t want, lib_pkg::res_t got);
        string names [6] = '{"drive_valid", "drive_level", "light_state", "changed_event",
                              "accepted", "pattern_full"};
        for (int i = 0; i < 6; i++)
            if (want[5-i] !== got[5-i])
            begin
                $error("%s: expected %0b, got %0b", names[i], want[5-i], got[5-i]);
                errors++;
            end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        lib_pkg::res_t got;
        lib_pkg::res_t want;
        if (!rst_n)
        begin
            en_reg = 1'b1;
            real_reg = 1'b0;
            lamp = 1'b0;
            tmr_on = 1'b0;
            tmr_pattern = 1'b0;
            tmr_left = '0;
            alt_level = 1'b1;
            loop_found = 1'b0;
            loop_at = '0;
            n_steps = '0;
            play_idx = '0;
            due_wr = 0;
            due_rd = 0;
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got = {res.drive_valid, res.drive_level, res.light_state, res.changed_event,
                       res.accepted, res.pattern_full};
                if (due_wr == due_rd)
                begin
                    $error("result item arrived with no expectation waiting");
                    errors++;
                end
                else
                begin
                    check_result(due_mem[due_rd % DUE_DEPTH], got);
                    due_rd++;
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == lib_pkg::CFG_ENABLED)
                    en_reg = cfg.data;
                else
                    real_reg = cfg.data;
            end
            if (req.valid && req.ready)
            begin
                want = light_outcome(req.req_type, req.level, req.duration_ms,
                                     req.entry_kind, req.first_entry, req.last_entry);
                if (due_wr - due_rd >= DUE_DEPTH)
                begin
                    $error("more items in flight than the block can hold");
                    errors++;
                end
                else
                begin
                    due_mem[due_wr % DUE_DEPTH] = want;
                    due_wr++;
                end
            end
            pending = due_wr - due_rd;
        end
    end

endmodule

@@ bench/tb.sv @@
// Top of the light impulse blink sequencer bench: clock, reset, request and configuration
// stimulus, result back-pressure and the verdict.
// Depends on lib_pkg, the channel interfaces, the block and blink_sequencer_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lib_pkg::KIND_W-1:0]     KIND_UNUSED    = 2'd3;
    localparam logic [lib_pkg::REQ_TYPE_W-1:0] REQ_UNKNOWN_LO = 3'd6;
    localparam logic [lib_pkg::REQ_TYPE_W-1:0] REQ_UNKNOWN_HI = 3'd7;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    logic en_now;
    logic quiet_tx;
    int   sent;
    int   counted;

    lib_req_if req_ch ();
    lib_res_if res_ch ();
    lib_cfg_if cfg_ch ();

    light_impulse_blink_sequencer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    blink_sequencer_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[light_impulse_blink_sequencer] ERROR");
        $finish;
    end

    // The receiver stalls for a random number of cycles before each item, and once
    // holds off for a long stretch so that the block fills up.
    initial
    begin : receiver
        int   gap;
        int   got;
        logic quiet;
        got = 0;
        quiet = 1'b0;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (got % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (got == 120)
                gap = 400;
            else
                gap = quiet ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res_ch.valid && res_ch.ready));
            got++;
        end
    end

    function automatic logic [23:0] pick_duration();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 24'($urandom);
        if (r < 3)
            return 24'($urandom_range(5, 40));
        return 24'($urandom_range(0, 4));
    endfunction

    task automatic send_request(logic [2:0] rq, logic lv, logic [23:0] dur, logic [1:0] kind,
                                logic first, logic last);
        int gap;
        if (sent % 40 == 0)
            quiet_tx = ($urandom_range(0, 3) == 0);
        gap = quiet_tx ? 0 : $urandom_range(0, 7);
        sent++;
        if (rq <= lib_pkg::REQ_TICK && (en_now || rq == lib_pkg::REQ_TICK))
            counted++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.req_type    <= rq;
        req_ch.level       <= lv;
        req_ch.duration_ms <= dur;
        req_ch.entry_kind  <= kind;
        req_ch.first_entry <= first;
        req_ch.last_entry  <= last;
        req_ch.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic send_tick();
        send_request(lib_pkg::REQ_TICK, 1'($urandom), 24'($urandom), 2'($urandom),
                     1'($urandom), 1'($urandom));
    endtask

    task automatic write_register(logic [lib_pkg::CFG_IDX_W-1:0] idx, logic val);
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == lib_pkg::CFG_ENABLED)
            en_now = val;
    endtask

    // A well-formed pattern: first entry opens it, last entry starts it, then ticks.
    // Now and then it is long enough to overflow the step table.
    task automatic play_pattern();
        int         n;
        int         pick;
        logic [1:0] kind;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                kind = lib_pkg::KIND_TIMED;
            else if (pick < 17)
                kind = lib_pkg::KIND_OLD;
            else if (pick < 19)
                kind = lib_pkg::KIND_LOOP;
            else
                kind = KIND_UNUSED;
            send_request(lib_pkg::REQ_PATTERN, 1'($urandom), pick_duration(), kind, i == 0,
                         i == n - 1);
        end
        repeat ($urandom_range(4, 30)) send_tick();
    endtask

    task automatic random_scenario();
        logic [2:0] simple_ops [3] = '{lib_pkg::REQ_SET, lib_pkg::REQ_TOGGLE,
                                       lib_pkg::REQ_SET_STATE};
        case ($urandom_range(0, 9)) inside
            [0:3]:
                play_pattern();
            [4:5]:
            begin
                send_request(lib_pkg::REQ_IMPULSE, 1'($urandom), pick_duration(), 2'($urandom),
                             1'($urandom), 1'($urandom));
                repeat ($urandom_range(1, 12)) send_tick();
            end
            6:
                send_request(simple_ops[$urandom_range(0, 2)], 1'($urandom), 24'($urandom),
                             2'($urandom), 1'($urandom), 1'($urandom));
            7:
                repeat ($urandom_range(1, 8)) send_tick();
            8:
                send_request(3'($urandom), 1'($urandom), 24'($urandom), 2'($urandom),
                             1'($urandom), 1'($urandom));
            default:
                repeat ($urandom_range(1, 4))
                    send_request(lib_pkg::REQ_PATTERN, 1'($urandom), pick_duration(),
                                 2'($urandom), 1'($urandom), 1'($urandom));
        endcase
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= lib_pkg::REQ_SET;
        req_ch.level       <= 1'b0;
        req_ch.duration_ms <= '0;
        req_ch.entry_kind  <= lib_pkg::KIND_TIMED;
        req_ch.first_entry <= 1'b0;
        req_ch.last_entry  <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= lib_pkg::CFG_ENABLED;
        cfg_ch.data  <= 1'b0;
        en_now = 1'b1;
        quiet_tx = 1'b0;
        sent = 0;
        counted = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_request(lib_pkg::REQ_SET, 1'b1, '0, lib_pkg::KIND_TIMED, 1'b0, 1'b0);
        send_request(lib_pkg::REQ_TOGGLE, 1'b0, '1, KIND_UNUSED, 1'b1, 1'b1);
        send_request(lib_pkg::REQ_SET_STATE, 1'b0, '0, lib_pkg::KIND_TIMED, 1'b0, 1'b0);
        send_request(lib_pkg::REQ_IMPULSE, 1'b0, 24'd0, lib_pkg::KIND_TIMED, 1'b0, 1'b0);
        send_tick();
        send_request(lib_pkg::REQ_IMPULSE, 1'b1, '1, lib_pkg::KIND_TIMED, 1'b0, 1'b0);
        send_tick();
        send_request(lib_pkg::REQ_SET, 1'b0, '0, lib_pkg::KIND_TIMED, 1'b0, 1'b0);

        // Timed, old-state, loop marker, timed, a second marker and an unused kind that
        // closes the pattern: the last step loops back onto itself.
        send_request(lib_pkg::REQ_PATTERN, 1'b0, 24'd1, lib_pkg::KIND_TIMED, 1'b1, 1'b0);
        send_request(lib_pkg::REQ_PATTERN, 1'b1, '1, lib_pkg::KIND_OLD, 1'b0, 1'b0);
        send_request(lib_pkg::REQ_PATTERN, 1'b0, '0, lib_pkg::KIND_LOOP, 1'b0, 1'b0);
        send_request(lib_pkg::REQ_PATTERN, 1'b0, 24'd0, lib_pkg::KIND_TIMED, 1'b0, 1'b0);
        send_request(lib_pkg::REQ_PATTERN, 1'b0, 24'd2, lib_pkg::KIND_LOOP, 1'b0, 1'b0);
        send_request(lib_pkg::REQ_PATTERN, 1'b1, '0, KIND_UNUSED, 1'b0, 1'b1);
        repeat (4) send_tick();
        send_request(lib_pkg::REQ_PATTERN, 1'b0, 24'd3, lib_pkg::KIND_TIMED, 1'b0, 1'b0);
        send_tick();

        // An empty pattern whose only entry is a loop marker.
        send_request(lib_pkg::REQ_PATTERN, 1'b0, '0, lib_pkg::KIND_LOOP, 1'b1, 1'b1);
        send_request(REQ_UNKNOWN_LO, 1'b1, '1, KIND_UNUSED, 1'b1, 1'b1);
        send_request(REQ_UNKNOWN_HI, 1'b0, '0, lib_pkg::KIND_TIMED, 1'b0, 1'b0);
        send_request(lib_pkg::REQ_IMPULSE, 1'b0, 24'd1, lib_pkg::KIND_TIMED, 1'b0, 1'b0);
        repeat (2) send_tick();

        counted = 0;
        while (counted < 220)
            random_scenario();
        write_register(lib_pkg::CFG_USE_REAL_STATE, 1'b1);
        while (counted < 350)
            random_scenario();
        write_register(lib_pkg::CFG_ENABLED, 1'b0);
        write_register(lib_pkg::CFG_USE_REAL_STATE, 1'b0);
        while (counted < 400)
            random_scenario();
        write_register(lib_pkg::CFG_ENABLED, 1'b1);
        while (counted < 550)
            random_scenario();

        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[light_impulse_blink_sequencer] OK");
        else
            $display("[light_impulse_blink_sequencer] ERROR");
        $finish;
    end

endmodule
